// ===== hdl/fbmp_pkg.sv =====
`timescale 1ns / 1ps

package fbmp_pkg;

  // field widths
  localparam int INDEX_BITS = 31;
  localparam int VALUE_BITS = 64;

  // the wide multiply is split into halves for a narrow multiplier
  localparam int HALF  = (VALUE_BITS + 1) / 2;
  localparam int MUL_W = 2 * HALF;

  // remaining-bit counter, wide enough to hold INDEX_BITS itself
  localparam int CNT_W = $clog2(INDEX_BITS + 1);

  // control word for one partial product issued to the multiply-accumulate unit
  typedef struct packed {
    logic valid;  // a partial product is issued this cycle
    logic first;  // starts a new product, clears the accumulator
    logic last;   // final partial of the product
    logic shift;  // cross term, weighted by 2^HALF
  } mac_op_t;

  // lower half of a value
  function automatic logic [HALF-1:0] lower_half(logic [VALUE_BITS-1:0] v);
    logic [MUL_W-1:0] w;
    w = MUL_W'(v);
    return w[HALF-1:0];
  endfunction

  // upper half of a value, zero-extended
  function automatic logic [HALF-1:0] upper_half(logic [VALUE_BITS-1:0] v);
    logic [MUL_W-1:0] w;
    w = MUL_W'(v);
    return w[MUL_W-1:HALF];
  endfunction

endpackage

// ===== hdl/fbmp_mac.sv =====
`timescale 1ns / 1ps

module fbmp_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [fbmp_pkg::HALF-1:0]      a_i,
  input  logic [fbmp_pkg::HALF-1:0]      b_i,
  input  fbmp_pkg::mac_op_t              op_i,
  output logic [fbmp_pkg::VALUE_BITS-1:0] acc_o,
  output logic                           done_o
);
  import fbmp_pkg::*;

  logic [MUL_W-1:0]      prod_q;
  mac_op_t               op_q;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [VALUE_BITS-1:0] addend;
  logic                  done_q;

  // product register, then accumulate in the cycle after
  always_ff @(posedge clk_i) begin
    prod_q <= MUL_W'(a_i) * MUL_W'(b_i);
  end

  always_comb begin
    if (op_q.shift) begin
      addend = {prod_q[VALUE_BITS-HALF-1:0], {HALF{1'b0}}};
    end else begin
      addend = prod_q[VALUE_BITS-1:0];
    end
    acc_d = (op_q.first ? '0 : acc_q) + addend;
  end

  always_ff @(posedge clk_i) begin
    if (op_q.valid) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= '0;
      done_q <= 1'b0;
    end else begin
      op_q   <= op_i;
      done_q <= op_q.valid & op_q.last;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// ===== hdl/fibonacci_by_matrix_power.sv =====
`timescale 1ns / 1ps

// fibonacci_by_matrix_power: returns F(n) modulo 2^64 for a 31-bit index n, by
// square-and-multiply on the Fibonacci matrix Q = [[1,1],[1,0]], scanning n from
// its top bit down. Q^k is held as hi = F(k+1) and mid = F(k) (the lower-right
// entry is hi - mid and is never stored). Each index bit costs three 64-bit
// products (hi*hi, mid*mid, mid*(2*hi - mid)), and each product is built from
// three 32x32 partial products on one shared multiply-accumulate unit. Every
// bit issues the partial products of its three products and then waits for the
// multiplier and accumulator pipeline to drain, for all 31 bits whatever n is.
// One transaction is taken at a time; in_stall_o is high from acceptance until
// the result is written to the output register, so a new index is not taken
// before the last one is done. The output register lets the next transaction
// start while an earlier result is still stalled downstream.

module fibonacci_by_matrix_power (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fbmp_pkg::INDEX_BITS-1:0] fib_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fbmp_pkg::VALUE_BITS-1:0] fib_value_o
);
  import fbmp_pkg::*;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,  // waiting for a transaction
    ST_MUL   = 4'b0010,  // issuing the nine partial products of one bit
    ST_DRAIN = 4'b0100,  // waiting for the last product of the bit
    ST_DONE  = 4'b1000   // result ready, output register still occupied
  } state_e;

  // which product of a bit is being issued
  localparam logic [1:0] PROD_HH = 2'd0;  // hi * hi
  localparam logic [1:0] PROD_MM = 2'd1;  // mid * mid
  localparam logic [1:0] PROD_MX = 2'd2;  // mid * (2*hi - mid)

  // which partial of a product is being issued
  localparam logic [1:0] PART_LL = 2'd0;  // low * low
  localparam logic [1:0] PART_LH = 2'd1;  // low * high
  localparam logic [1:0] PART_HL = 2'd2;  // high * low

  state_e                state_q, state_d;
  logic [INDEX_BITS-1:0] n_q, n_d;         // index, shifted left as bits are used
  logic [CNT_W-1:0]      cnt_q, cnt_d;     // bits still to process
  logic [1:0]            prod_q, prod_d;
  logic [1:0]            part_q, part_d;
  logic [1:0]            res_cnt_q, res_cnt_d;  // products of this bit returned
  logic [VALUE_BITS-1:0] hi_q, hi_d;       // F(k+1)
  logic [VALUE_BITS-1:0] mid_q, mid_d;     // F(k)
  logic [VALUE_BITS-1:0] s_q, s_d;         // hi + lo = 2*hi - mid
  logic [VALUE_BITS-1:0] t0_q, t0_d;       // hi*hi, then hi*hi + mid*mid
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;

  // shared unit interface
  mac_op_t               mac_op;
  logic [VALUE_BITS-1:0] opa_full, opb_full;
  logic [HALF-1:0]       mac_a, mac_b;
  logic [VALUE_BITS-1:0] mac_acc;
  logic                  mac_done;

  // values after the squaring and the optional step by Q
  logic [VALUE_BITS-1:0] hi_new, mid_new;
  logic                  out_free;
  logic                  in_accept;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // operand selection for the current partial product
  always_comb begin
    if (prod_q == PROD_HH) begin
      opa_full = hi_q;
      opb_full = hi_q;
    end else if (prod_q == PROD_MM) begin
      opa_full = mid_q;
      opb_full = mid_q;
    end else begin
      opa_full = mid_q;
      opb_full = s_q;
    end
    mac_a = (part_q == PART_HL) ? upper_half(opa_full) : lower_half(opa_full);
    mac_b = (part_q == PART_LH) ? upper_half(opb_full) : lower_half(opb_full);

    mac_op       = '0;
    mac_op.valid = (state_q == ST_MUL);
    mac_op.first = (part_q == PART_LL);
    mac_op.last  = (part_q == PART_HL);
    mac_op.shift = (part_q != PART_LL);
  end

  fbmp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .op_i   (mac_op),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  // new matrix once mid*(hi+lo) arrives; a set bit multiplies by Q
  always_comb begin
    if (n_q[INDEX_BITS-1]) begin
      hi_new  = t0_q + mac_acc;
      mid_new = t0_q;
    end else begin
      hi_new  = t0_q;
      mid_new = mac_acc;
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    part_d      = part_q;
    res_cnt_d   = res_cnt_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    s_d         = s_q;
    t0_d        = t0_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // collect returned products
    if (mac_done) begin
      unique case (res_cnt_q)
        2'd0: begin
          t0_d      = mac_acc;
          res_cnt_d = 2'd1;
        end
        2'd1: begin
          t0_d      = t0_q + mac_acc;
          res_cnt_d = 2'd2;
        end
        default: begin
          res_cnt_d = 2'd0;
        end
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          n_d       = fib_index_i;
          cnt_d     = CNT_W'(INDEX_BITS);
          hi_d      = VALUE_BITS'(1);
          mid_d     = '0;
          prod_d    = PROD_HH;
          part_d    = PART_LL;
          res_cnt_d = 2'd0;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (prod_q == PROD_HH && part_q == PART_LL) begin
          s_d = (hi_q << 1) - mid_q;
        end
        if (part_q == PART_HL) begin
          part_d = PART_LL;
          if (prod_q == PROD_MX) begin
            prod_d  = PROD_HH;
            state_d = ST_DRAIN;
          end else begin
            prod_d = prod_q + 2'd1;
          end
        end else begin
          part_d = part_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          hi_d  = hi_new;
          mid_d = mid_new;
          n_d   = n_q << 1;
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            // last bit: hand the result on, or hold it until the output frees
            if (out_free) begin
              out_valid_d = 1'b1;
              out_value_d = mid_new;
              state_d     = ST_IDLE;
            end else begin
              state_d = ST_DONE;
            end
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = mid_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prod_q      <= PROD_HH;
      part_q      <= PART_LL;
      res_cnt_q   <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prod_q      <= prod_d;
      part_q      <= part_d;
      res_cnt_q   <= res_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    s_q         <= s_d;
    t0_q        <= t0_d;
    out_value_q <= out_value_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign fib_value_o = out_value_q;

  // products only come back while a transaction is in progress
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_MUL || state_q == ST_DRAIN))
    else $error("product returned outside a transaction");

  // the first two products of a bit are in before the drain starts
  a_drain_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (res_cnt_q == 2'd2))
    else $error("drain entered with products missing");

  // an accepted transaction starts issuing at once
  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_MUL && prod_q == PROD_HH && part_q == PART_LL))
    else $error("accepted transaction did not start");

endmodule

// ===== test/fbmp_value_checker.sv =====
`timescale 1ns / 1ps

module fbmp_value_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [fbmp_pkg::INDEX_BITS-1:0] fib_index_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [fbmp_pkg::VALUE_BITS-1:0] fib_value_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import fbmp_pkg::*;

  typedef struct {
    logic [INDEX_BITS-1:0] index;
    logic [VALUE_BITS-1:0] value;
  } fib_expect_t;

  fib_expect_t expected_fib[$];

  // Q^k held as [[diag_hi, off], [off, diag_lo]], scanned from the top index bit
  function automatic logic [VALUE_BITS-1:0] fib_mod64(logic [INDEX_BITS-1:0] n);
    logic [VALUE_BITS-1:0] diag_hi, off, diag_lo, off_sq, nxt_hi, nxt_off, nxt_lo;
    diag_hi = VALUE_BITS'(1);
    off     = '0;
    diag_lo = VALUE_BITS'(1);
    for (int k = INDEX_BITS - 1; k >= 0; k--) begin
      off_sq  = off * off;
      nxt_hi  = diag_hi * diag_hi + off_sq;
      nxt_off = off * (diag_hi + diag_lo);
      nxt_lo  = off_sq + diag_lo * diag_lo;
      diag_hi = nxt_hi;
      off     = nxt_off;
      diag_lo = nxt_lo;
      if (n[k]) begin
        // times Q
        diag_lo = off;
        off     = diag_hi;
        diag_hi = diag_hi + diag_lo;
      end
    end
    return off;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fib_expect_t exp_item;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_fib.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual fib_value %h",
                   $time, fib_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = expected_fib.pop_front();
          if (fib_value_i !== exp_item.value) begin
            $display("%0t: fib_value mismatch for index %0d, expected %h, actual %h",
                     $time, exp_item.index, exp_item.value, fib_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp_item.index = fib_index_i;
        exp_item.value = fib_mod64(fib_index_i);
        expected_fib.push_back(exp_item);
      end
      pending_o <= expected_fib.size();
    end
  end

endmodule

// ===== test/fibonacci_by_matrix_power_tb.sv =====
`timescale 1ns / 1ps

module fibonacci_by_matrix_power_tb;
  import fbmp_pkg::*;

  // block processes every index bit for each index, so the run is long in cycles
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned DRAIN_CYCLES = 800;
  localparam int unsigned RANDOM_ITEMS = 980;
  localparam int unsigned HOLD_AFTER   = 100;   // results seen before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 3000;  // long enough to back up the input side

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [INDEX_BITS-1:0] fib_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [VALUE_BITS-1:0] fib_value_o;

  int unsigned fail_count;
  int unsigned pending;

  // idle percentages, changed by the sender as the run moves through its phases
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 84;
  int unsigned items_sent    = 0;

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fibonacci_by_matrix_power u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .fib_index_i (fib_index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .fib_value_o (fib_value_o)
  );

  fbmp_value_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .fib_index_i  (fib_index_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fib_value_i  (fib_value_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // offer one index; idle first at random, then hold valid and payload until taken
  task automatic offer_index(input logic [INDEX_BITS-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    fib_index_i <= idx;
    // in_stall_o read here is the value from before this edge
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // idle mix follows the transaction count: sender light / receiver heavy,
  // then the reverse, then no idling at all
  task automatic set_phase();
    int unsigned total;
    total = RANDOM_ITEMS + 20;
    if (items_sent < total / 3) begin
      send_idle_pct = 29;
      recv_idle_pct = 84;
    end else if (items_sent < (2 * total) / 3) begin
      send_idle_pct = 84;
      recv_idle_pct = 29;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // random index, weighted toward small values and the 64-bit overflow region
  function automatic logic [INDEX_BITS-1:0] random_index();
    int unsigned pick;
    int unsigned b;
    logic [INDEX_BITS-1:0] v;
    pick = $urandom_range(99);
    b    = $urandom_range(INDEX_BITS - 1);
    if (pick < 40) begin
      v = INDEX_BITS'($urandom());
    end else if (pick < 65) begin
      v = INDEX_BITS'($urandom_range(200));
    end else if (pick < 80) begin
      // F(93) is the last value that fits in 64 bits
      v = INDEX_BITS'($urandom_range(110, 80));
    end else if (pick < 85) begin
      v = '0;
      v[b] = 1'b1;
    end else if (pick < 90) begin
      v = '1;
      v = v >> b;
    end else begin
      // top bit set, rest random
      v = INDEX_BITS'($urandom());
      v[INDEX_BITS-1] = 1'b1;
    end
    return v;
  endfunction

  // sender and verdict
  initial begin
    logic [INDEX_BITS-1:0] directed[$];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, smallest indexes, overflow boundary, extremes, bit patterns
    directed = '{
      INDEX_BITS'(0), INDEX_BITS'(1), INDEX_BITS'(2), INDEX_BITS'(3),
      INDEX_BITS'(10), INDEX_BITS'(92), INDEX_BITS'(93), INDEX_BITS'(94),
      INDEX_BITS'(95), INDEX_BITS'(100), INDEX_BITS'(1000), INDEX_BITS'(65535),
      INDEX_BITS'(65536), INDEX_BITS'(31'h4000_0000), INDEX_BITS'(31'h7fff_fffe),
      INDEX_BITS'(31'h7fff_ffff), INDEX_BITS'(31'h5555_5555), INDEX_BITS'(31'h2aaa_aaaa),
      INDEX_BITS'(31'h0000_ffff), INDEX_BITS'(31'h7fff_0000)
    };
    foreach (directed[i]) begin
      set_phase();
      offer_index(directed[i]);
    end

    repeat (RANDOM_ITEMS) begin
      set_phase();
      offer_index(random_index());
    end
    in_valid_i <= 1'b0;

    // wait for every outstanding result, then let the pipeline settle
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("** fibonacci_by_matrix_power: PASSED **");
    end else begin
      $display("** fibonacci_by_matrix_power: FAILED **");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off that fills the block
  initial begin
    int unsigned results_seen;
    int unsigned hold_left;
    bit          hold_done;
    results_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // sender keeps offering while this runs, so the block fills and in_stall_o stays high
        out_stall_i <= 1'b1;
        hold_left   = HOLD_CYCLES;
        hold_done   = 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("** fibonacci_by_matrix_power: FAILED **");
    $finish;
  end

endmodule
